### rtl/core/tks_pkg.sv
// Types, constants and helper functions shared by the token scanner modules.
// No dependencies.
package tks_pkg;

    localparam int unsigned MAX_LEXEME_LEN = 255;
    localparam int unsigned MAX_POSITION   = 65535;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam logic [7:0]  LEN_LIM = (MAX_LEXEME_LEN < 255) ? 8'(MAX_LEXEME_LEN) : 8'd255;
    localparam logic [15:0] POS_LIM = (MAX_POSITION < 65535) ? 16'(MAX_POSITION) : 16'hFFFF;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;

    localparam logic [2:0] SYM_ASSIGN = 3'd0;
    localparam logic [2:0] SYM_PLUS   = 3'd1;
    localparam logic [2:0] SYM_STAR   = 3'd2;
    localparam logic [2:0] SYM_LPAREN = 3'd3;
    localparam logic [2:0] SYM_RPAREN = 3'd4;

    localparam logic [4:0] ALL_KEYWORDS = 5'h1F;

    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_SYMBOL  = 3'd3,
        KIND_END     = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_COLON = 3'd3,
        MODE_DRAIN = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  keyword_id;
        logic [2:0]  symbol_id;
        logic [15:0] start_offset;
        logic [7:0]  lexeme_length;
        logic        length_saturated;
        logic [7:0]  bad_char;
        logic        run_end;
    } t_out_word;

    typedef struct packed {
        logic [1:0]          count;
        t_out_word [2:0]     slot;
    } t_bundle;

    function automatic logic [39:0] kw_text(logic [2:0] k);
        logic [39:0] t;
        unique case (k)
            3'd0:    t = {"if", 24'd0};
            3'd1:    t = {"then", 8'd0};
            3'd2:    t = {"else", 8'd0};
            3'd3:    t = "while";
            3'd4:    t = {"do", 24'd0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] kw_len(logic [2:0] k);
        logic [7:0] l;
        unique case (k)
            3'd0:    l = 8'd2;
            3'd1:    l = 8'd4;
            3'd2:    l = 8'd4;
            3'd3:    l = 8'd5;
            3'd4:    l = 8'd2;
            default: l = 8'd0;
        endcase
        return l;
    endfunction

    function automatic logic [4:0] kw_match(logic [4:0] cand, logic [7:0] idx, logic [7:0] c);
        logic [4:0]  keep;
        logic [39:0] txt;
        int          pos;
        keep = '0;
        for (int k = 0; k < 5; k++) begin
            txt = kw_text(3'(k));
            pos = 39 - 8 * int'(idx[2:0]);
            if (cand[k] && (idx < kw_len(3'(k)))) begin
                if (txt[pos -: 8] == c) begin
                    keep[k] = 1'b1;
                end
            end
        end
        return keep;
    endfunction

    function automatic t_out_word make_word(t_kind kind, logic [2:0] kw, logic [2:0] sym,
                                            logic [15:0] start, logic [7:0] len,
                                            logic flag, logic [7:0] bad);
        t_out_word w;
        w.kind             = kind;
        w.keyword_id       = kw;
        w.symbol_id        = sym;
        w.start_offset     = start;
        w.lexeme_length    = len;
        w.length_saturated = flag | (start == POS_LIM) | (len == LEN_LIM);
        w.bad_char         = bad;
        w.run_end          = 1'b0;
        return w;
    endfunction

    function automatic t_out_word close_word(logic is_word, logic [4:0] cand, logic [7:0] len,
                                             logic [15:0] start, logic ovf);
        t_kind      kind;
        logic [2:0] kw;
        kind = is_word ? KIND_IDENT : KIND_NUMBER;
        kw   = 3'd0;
        if (is_word) begin
            for (int k = 0; k < 5; k++) begin
                if (cand[k] && (kw_len(3'(k)) == len)) begin
                    kind = KIND_KEYWORD;
                    kw   = 3'(k);
                end
            end
        end
        return make_word(kind, kw, 3'd0, start, len, ovf, 8'd0);
    endfunction

endpackage

### rtl/core/token_scanner.sv
// Token scanner top level: character stream in, token descriptor words out.
// Depends on tks_pkg, tks_front, tks_queue and tks_back.
//
// The input channel takes one character word per cycle (i_in_valid with
// o_in_stall); the word carries the byte and a flag for the last character.
// The output channel gives one token word per cycle (o_out_valid with
// i_out_stall): kind, keyword or symbol code, start offset, length, a
// saturation flag, the bad byte of an error and a flag on the final word
// caused by one character.
// A character is decoded in the cycle it is accepted and its zero to three
// token words enter a queue of QUEUE_DEPTH bundles; the back end moves them
// into the output register one a cycle while the receiver does not stall.
// Throughput is one character per cycle; it drops while the receiver stalls or
// while the output port, at one word a cycle, drains characters with several words.
// When the receiver stalls, the output word holds and the queue fills; once
// it is full, o_in_stall rises until the back end frees an entry.
// Reset empties the queue and the output register and returns the scanner
// to the start of a new text; the character after a last word also starts a
// new text at offset zero.
module token_scanner #(
    parameter int unsigned QUEUE_DEPTH = tks_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tks_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tks_pkg::t_out_word o_out_word
);

    logic             accept, q_push, q_full, q_pop, q_empty;
    tks_pkg::t_bundle q_in, q_head;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    tks_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .o_push   (q_push),
        .o_bundle (q_in)
    );

    tks_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_head),
        .o_empty     (q_empty)
    );

    tks_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

`ifndef SYNTH
    a_pop_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_end_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.kind == tks_pkg::KIND_END)) |-> o_out_word.run_end)
        else $error("end token not marked as final word");

    a_reset_clears : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("bundle pushed into a full queue");
`endif

endmodule

### rtl/core/tks_front.sv
// Front end of the token scanner: takes one character per cycle while
// i_accept is high, tracks the token in progress and produces a bundle of up
// to three result words. Depends on tks_pkg.
module tks_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tks_pkg::t_in_word i_word,
    output logic              o_push,
    output tks_pkg::t_bundle  o_bundle
);

    tks_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_pos, n_pos;
    logic [15:0]    r_start, n_start;
    logic [7:0]     r_len, n_len;
    logic [4:0]     r_cand, n_cand;
    logic           r_ovf, n_ovf;

    tks_pkg::t_mode m_mode;
    logic [15:0]    m_start;
    logic [7:0]     m_len;
    logic [4:0]     m_cand;
    logic           m_ovf;

    logic [7:0]  c;
    logic        is_alpha, is_digit, is_space, is_word_ch, is_sym;
    logic        in_word, in_num, cont, close_now, fresh;
    logic        colon_ok, colon_err, start_word, start_num, start_colon;
    logic        sym_now, err_now;
    logic [2:0]  sym_code;
    logic [15:0] pos_next;
    logic [7:0]  len_inc;

    always_comb begin
        c          = i_word.ch;
        is_alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        is_digit   = (c >= "0") && (c <= "9");
        is_space   = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
        is_word_ch = is_alpha || is_digit || (c == tks_pkg::CH_UNDERSCORE);
        is_sym     = 1'b1;
        sym_code   = tks_pkg::SYM_PLUS;
        unique case (c)
            tks_pkg::CH_PLUS:   sym_code = tks_pkg::SYM_PLUS;
            tks_pkg::CH_STAR:   sym_code = tks_pkg::SYM_STAR;
            tks_pkg::CH_LPAREN: sym_code = tks_pkg::SYM_LPAREN;
            tks_pkg::CH_RPAREN: sym_code = tks_pkg::SYM_RPAREN;
            default:            is_sym   = 1'b0;
        endcase

        in_word     = (r_mode == tks_pkg::MODE_WORD);
        in_num      = (r_mode == tks_pkg::MODE_NUM);
        cont        = (in_word && is_word_ch) || (in_num && is_digit);
        close_now   = (in_word || in_num) && !cont;
        fresh       = (r_mode == tks_pkg::MODE_IDLE) || close_now;
        colon_ok    = (r_mode == tks_pkg::MODE_COLON) && (c == tks_pkg::CH_EQUAL);
        colon_err   = (r_mode == tks_pkg::MODE_COLON) && (c != tks_pkg::CH_EQUAL);
        start_word  = fresh && (is_alpha || (c == tks_pkg::CH_UNDERSCORE));
        start_num   = fresh && is_digit;
        start_colon = fresh && (c == tks_pkg::CH_COLON);
        sym_now     = fresh && is_sym;
        err_now     = fresh && !is_space && !start_word && !start_num && !start_colon
                      && !is_sym;

        pos_next = (r_pos < tks_pkg::POS_LIM) ? r_pos + 16'd1 : r_pos;
        len_inc  = (r_len < tks_pkg::LEN_LIM) ? r_len + 8'd1 : r_len;

        m_mode  = r_mode;
        m_start = r_start;
        m_len   = r_len;
        m_cand  = r_cand;
        m_ovf   = r_ovf;
        if (colon_ok) begin
            m_mode = tks_pkg::MODE_IDLE;
        end else if (colon_err) begin
            m_mode = tks_pkg::MODE_DRAIN;
        end else if (cont) begin
            m_cand = tks_pkg::kw_match(r_cand, r_len, c);
            m_len  = len_inc;
            m_ovf  = r_ovf || (len_inc == tks_pkg::LEN_LIM);
        end else if (fresh) begin
            m_mode = tks_pkg::MODE_IDLE;
            if (start_word || start_num) begin
                m_mode  = start_word ? tks_pkg::MODE_WORD : tks_pkg::MODE_NUM;
                m_start = r_pos;
                m_len   = 8'd1;
                m_ovf   = (r_pos == tks_pkg::POS_LIM) || (tks_pkg::LEN_LIM == 8'd1);
                if (start_word) begin
                    m_cand = tks_pkg::kw_match(tks_pkg::ALL_KEYWORDS, 8'd0, c);
                end
            end else if (start_colon) begin
                m_mode  = tks_pkg::MODE_COLON;
                m_start = r_pos;
            end else if (err_now) begin
                m_mode = tks_pkg::MODE_DRAIN;
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_cand  = r_cand;
        n_ovf   = r_ovf;
        if (i_accept) begin
            if (i_word.last) begin
                n_mode  = tks_pkg::MODE_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_len   = '0;
                n_cand  = tks_pkg::ALL_KEYWORDS;
                n_ovf   = 1'b0;
            end else begin
                n_mode  = m_mode;
                n_pos   = pos_next;
                n_start = m_start;
                n_len   = m_len;
                n_cand  = m_cand;
                n_ovf   = m_ovf;
            end
        end
    end

    always_comb begin
        logic [1:0] n;
        n        = 2'd0;
        o_bundle = '0;
        if (close_now) begin
            o_bundle.slot[n] = tks_pkg::close_word(in_word, r_cand, r_len, r_start, r_ovf);
            n = n + 2'd1;
        end
        if (colon_ok) begin
            o_bundle.slot[n] = tks_pkg::make_word(tks_pkg::KIND_SYMBOL, 3'd0,
                tks_pkg::SYM_ASSIGN, r_start, 8'd2, 1'b0, 8'd0);
            n = n + 2'd1;
        end else if (colon_err) begin
            o_bundle.slot[n] = tks_pkg::make_word(tks_pkg::KIND_ERROR, 3'd0, 3'd0,
                r_start, 8'd1, 1'b0, tks_pkg::CH_COLON);
            n = n + 2'd1;
        end else if (sym_now) begin
            o_bundle.slot[n] = tks_pkg::make_word(tks_pkg::KIND_SYMBOL, 3'd0, sym_code,
                r_pos, 8'd1, 1'b0, 8'd0);
            n = n + 2'd1;
        end else if (err_now) begin
            o_bundle.slot[n] = tks_pkg::make_word(tks_pkg::KIND_ERROR, 3'd0, 3'd0,
                r_pos, 8'd1, 1'b0, c);
            n = n + 2'd1;
        end
        if (i_word.last) begin
            if ((m_mode == tks_pkg::MODE_WORD) || (m_mode == tks_pkg::MODE_NUM)) begin
                o_bundle.slot[n] = tks_pkg::close_word(m_mode == tks_pkg::MODE_WORD,
                    m_cand, m_len, m_start, m_ovf);
                n = n + 2'd1;
            end else if (m_mode == tks_pkg::MODE_COLON) begin
                o_bundle.slot[n] = tks_pkg::make_word(tks_pkg::KIND_ERROR, 3'd0, 3'd0,
                    m_start, 8'd1, 1'b0, tks_pkg::CH_COLON);
                n = n + 2'd1;
            end
            o_bundle.slot[n] = tks_pkg::make_word(tks_pkg::KIND_END, 3'd0, 3'd0,
                pos_next, 8'd0, 1'b0, 8'd0);
            n = n + 2'd1;
        end
        o_bundle.count = n;
        o_push         = i_accept && (n != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tks_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_cand  <= tks_pkg::ALL_KEYWORDS;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_cand  <= n_cand;
            r_ovf   <= n_ovf;
        end
    end

endmodule

### rtl/core/tks_queue.sv
// Short queue of result bundles between the scanner front and back ends.
// Depends on tks_pkg.
module tks_queue #(
    parameter int unsigned DEPTH = tks_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tks_pkg::t_bundle i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output tks_pkg::t_bundle o_pop_data,
    output logic             o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tks_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full     = (r_cnt == FULL_CNT);
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### rtl/core/tks_back.sv
// Back end of the token scanner: unpacks queued bundles into single result
// words held in the output register. Depends on tks_pkg.
module tks_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  tks_pkg::t_bundle   i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output tks_pkg::t_out_word o_word
);

    logic               r_valid;
    logic [1:0]         r_slot;
    tks_pkg::t_out_word r_word, n_word;
    logic               load, last_slot;

    always_comb begin
        load           = !i_empty && (!r_valid || !i_stall);
        last_slot      = (r_slot == (i_head.count - 2'd1));
        o_pop          = load && last_slot;
        n_word         = i_head.slot[r_slot];
        n_word.run_end = last_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= last_slot ? 2'd0 : r_slot + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
